@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the indexed list engine.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ILE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The condition must never be true outside reset.
`define ILE_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ hw/rtl/ile_pkg.sv @@
// Shared types and constants of the indexed list engine.
// No dependencies; every other file of the block but assert_macros.svh imports this package.
package ile_pkg;

  localparam int WORD_W       = 64;
  localparam int KIND_W       = 3;
  localparam int POS_W        = 7;
  localparam int STAT_W       = 3;
  localparam int LEN_W        = 7;
  localparam int DEF_CAPACITY = 64;

  localparam logic [KIND_W-1:0] KIND_PUSH   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_POP    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REMAT  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REMVAL = 3'd4;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_RANGE    = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic              shift_en;
    logic [WORD_W-1:0] tail_word;
  } ile_chain_ctl_t;

endpackage

@@ hw/rtl/ile_if.sv @@
// Request and result channel interfaces of the indexed list engine.
// Depends on ile_pkg for the field widths.
interface ile_req_if import ile_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [POS_W-1:0]  position;
  logic [WORD_W-1:0] word_in;

  modport source (output valid, output kind, output position, output word_in, input ready);
  modport sink (input valid, input kind, input position, input word_in, output ready);
endinterface

interface ile_rsp_if import ile_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] word_out;
  logic [STAT_W-1:0] status;
  logic [LEN_W-1:0]  length_now;

  modport source (output valid, output word_out, output status, output length_now,
                  input ready);
  modport sink (input valid, input word_out, input status, input length_now,
                output ready);
endinterface

@@ hw/rtl/ile_cell.sv @@
// One storage cell of the list chain: a word that moves one place per shift.
// Depends on ile_pkg for the default word width.
module ile_cell import ile_pkg::*; #(
  parameter int CELL_W = WORD_W
) (
  input  logic              clk,
  input  logic              shift_en,
  input  logic [CELL_W-1:0] d_in,
  output logic [CELL_W-1:0] q_out
);

  logic [CELL_W-1:0] word_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      word_r <= d_in;
    end
  end

  assign q_out = word_r;

endmodule

@@ hw/rtl/ile_chain.sv @@
// Row of ile_cell instances holding the list, entry 0 at the head.
// Depends on ile_pkg and ile_cell; the tail cell is fed by the sequencer.
module ile_chain import ile_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic              clk,
  input  ile_chain_ctl_t    ctl,
  output logic [WORD_W-1:0] head_word
);

  logic [WORD_W-1:0] cell_q [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_W-1:0] cell_d;

    if (i == CAPACITY - 1) begin : g_tail
      assign cell_d = ctl.tail_word;
    end else begin : g_body
      assign cell_d = cell_q[i+1];
    end

    ile_cell #(.CELL_W(WORD_W)) u_cell (
      .clk      (clk),
      .shift_en (ctl.shift_en),
      .d_in     (cell_d),
      .q_out    (cell_q[i])
    );
  end

  assign head_word = cell_q[0];

endmodule

@@ hw/rtl/ile_ctrl.sv @@
// Request sequencer of the indexed list engine: checks, rotation pass, result beat.
// Depends on ile_pkg and the channel interfaces; drives the cell chain.
module ile_ctrl import ile_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic              clk,
  input  logic              rst_n,
  ile_req_if.sink           in_if,
  ile_rsp_if.source         out_if,
  input  logic [WORD_W-1:0] head_word,
  output ile_chain_ctl_t    chain_ctl
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PASS = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     t_r, t_nxt;
  logic [IW-1:0]     p_r, p_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [WORD_W-1:0] res_r, res_nxt;
  logic              hit_d_r, hit_d_nxt;
  logic              past_r, past_nxt;
  logic              found_r, found_nxt;
  logic [WORD_W-1:0] hold1_r, hold1_nxt;
  logic [WORD_W-1:0] hold2_r, hold2_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_word_r, out_word_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [LEN_W-1:0]  out_len_r, out_len_nxt;

  logic [IW-1:0]     cnt_x;
  logic [IW-1:0]     pos_x;
  logic              full;
  logic              ins_mode;
  logic              rem_mode;
  logic              cap_mode;
  logic              hit_now;
  logic [WORD_W-1:0] tail_word;

  assign cnt_x = IW'(count_r);
  assign pos_x = IW'(in_if.position);
  assign full  = (count_r == CAP_C);

  assign ins_mode = (kind_r == KIND_PUSH) || (kind_r == KIND_INSERT);
  assign rem_mode = (kind_r == KIND_POP) || (kind_r == KIND_REMAT) ||
                    (kind_r == KIND_REMVAL);
  assign cap_mode = rem_mode || (kind_r == KIND_READ);

  // The head cell shows original entry t while the pass counter t_r equals t.
  assign hit_now = (kind_r == KIND_REMVAL) ?
                   (!found_r && (t_r < count_r) && (head_word == word_r)) :
                   (IW'(t_r) == p_r);

  // Each tail write is new entry t-1; hold1 holds the previous head word and hold2 the one before it.
  always_comb begin
    if (ins_mode) begin
      tail_word = hit_d_r ? word_r : (past_r ? hold2_r : hold1_r);
    end else if (rem_mode && found_r) begin
      tail_word = head_word;
    end else begin
      tail_word = hold1_r;
    end
  end

  assign chain_ctl.shift_en  = (state_r == S_PASS);
  assign chain_ctl.tail_word = tail_word;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    t_nxt          = t_r;
    p_nxt          = p_r;
    kind_nxt       = kind_r;
    word_nxt       = word_r;
    status_nxt     = status_r;
    res_nxt        = res_r;
    hit_d_nxt      = hit_d_r;
    past_nxt       = past_r;
    found_nxt      = found_r;
    hold1_nxt      = hold1_r;
    hold2_nxt      = hold2_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_word_nxt   = out_word_r;
    out_status_nxt = out_status_r;
    out_len_nxt    = out_len_r;

    case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          kind_nxt   = in_if.kind;
          word_nxt   = in_if.word_in;
          t_nxt      = '0;
          p_nxt      = pos_x;
          hit_d_nxt  = 1'b0;
          past_nxt   = 1'b0;
          found_nxt  = 1'b0;
          res_nxt    = '0;
          status_nxt = ST_OK;
          state_nxt  = S_PASS;
          case (in_if.kind)
            KIND_PUSH: begin
              p_nxt = cnt_x;
              if (full) begin
                status_nxt = ST_FULL;
                state_nxt  = S_RESP;
              end
            end
            KIND_POP: begin
              p_nxt = cnt_x - IW'(1);
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_RESP;
              end
            end
            KIND_INSERT: begin
              if (pos_x > cnt_x) begin
                status_nxt = ST_RANGE;
                state_nxt  = S_RESP;
              end else if (full) begin
                status_nxt = ST_FULL;
                state_nxt  = S_RESP;
              end
            end
            KIND_REMAT, KIND_READ: begin
              if (pos_x >= cnt_x) begin
                status_nxt = ST_RANGE;
                state_nxt  = S_RESP;
              end
            end
            KIND_REMVAL: begin
              state_nxt = S_PASS;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_PASS: begin
        hold1_nxt = head_word;
        hold2_nxt = hold1_r;
        hit_d_nxt = hit_now;
        past_nxt  = past_r || hit_d_r;
        found_nxt = found_r || hit_now;
        t_nxt     = t_r + 1'b1;
        if (cap_mode && hit_now) begin
          res_nxt = head_word;
        end
        if (t_r == CAP_C) begin
          state_nxt = S_RESP;
          if (ins_mode) begin
            count_nxt = count_r + 1'b1;
          end else if (rem_mode && found_r) begin
            count_nxt = count_r - 1'b1;
          end
          if ((kind_r == KIND_REMVAL) && !found_r) begin
            status_nxt = ST_NOTFOUND;
          end
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt  = 1'b1;
          out_word_nxt   = res_r;
          out_status_nxt = status_r;
          out_len_nxt    = LEN_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r          <= t_nxt;
    p_r          <= p_nxt;
    kind_r       <= kind_nxt;
    word_r       <= word_nxt;
    status_r     <= status_nxt;
    res_r        <= res_nxt;
    hit_d_r      <= hit_d_nxt;
    past_r       <= past_nxt;
    found_r      <= found_nxt;
    hold1_r      <= hold1_nxt;
    hold2_r      <= hold2_nxt;
    out_word_r   <= out_word_nxt;
    out_status_r <= out_status_nxt;
    out_len_r    <= out_len_nxt;
  end

  assign in_if.ready       = (state_r == S_IDLE);
  assign out_if.valid      = out_valid_r;
  assign out_if.word_out   = out_word_r;
  assign out_if.status     = out_status_r;
  assign out_if.length_now = out_len_r;

endmodule

@@ hw/rtl/indexed_list_engine_top.sv @@
// Top level of the indexed list engine: sequencer plus chain of list cells.
// Depends on ile_pkg, ile_if, ile_cell, ile_chain, ile_ctrl and assert_macros.svh.
//
// The list lives in a chain of CAPACITY word cells. A request that passes its checks
// rotates the whole chain once through the sequencer, which reads the head cell and
// rebuilds the list at the tail. The sequencer accepts the request, runs the pass, then
// loads the result register once the previous beat is collected; only then is a new
// request taken. A request that fails its checks (full, empty, index out of range) or
// carries an unused kind leaves the list alone and skips the pass. Remove by value
// reports not found only after the full pass. One result beat follows every request,
// and the next request is taken while that beat waits to be collected.
`include "assert_macros.svh"

module indexed_list_engine_top import ile_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic      clk,
  input  logic      rst_n,
  ile_req_if.sink   in_if,
  ile_rsp_if.source out_if
);

  ile_chain_ctl_t    chain_ctl;
  logic [WORD_W-1:0] head_word;

  ile_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .head_word (head_word),
    .chain_ctl (chain_ctl)
  );

  ile_chain #(.CAPACITY(CAPACITY)) u_chain (
    .clk       (clk),
    .ctl       (chain_ctl),
    .head_word (head_word)
  );

  `ILE_ASSERT(a_len_bound, out_if.valid |-> (int'(out_if.length_now) <= CAPACITY), "length beyond capacity")
  `ILE_ASSERT(a_full_len, (out_if.valid && (out_if.status == ST_FULL)) |-> (out_if.length_now == LEN_W'(CAPACITY)), "full status with short list")
  `ILE_ASSERT(a_empty_len, (out_if.valid && (out_if.status == ST_EMPTY)) |-> (out_if.length_now == '0), "empty status with entries held")
  `ILE_ASSERT(a_fail_zero, (out_if.valid && (out_if.status != ST_OK)) |-> (out_if.word_out == '0), "failed request returned a word")
  `ILE_NEVER(a_shift_idle, chain_ctl.shift_en && in_if.ready, "chain shifting while requests are taken")

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for indexed_list_engine_top: random and directed list requests.
// Needs ile_pkg, ile_req_if and ile_rsp_if from the RTL; predicts every reply in a scoreboard.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ile_pkg::*;

  localparam int CAP          = DEF_CAPACITY;
  localparam int QUIET_LIMIT  = 4000;
  localparam int REPORT_LIMIT = 10;

  localparam logic [KIND_W-1:0] KIND_SPARE6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE7 = 3'd7;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  len;
  } list_reply_t;

  class list_scoreboard;
    logic [WORD_W-1:0] cells [CAP];
    int                count = 0;
    int                mismatches = 0;
    list_reply_t       replies [$];

    function logic [WORD_W-1:0] take_at(input int at);
      logic [WORD_W-1:0] w;
      w = cells[at];
      for (int i = at; i + 1 < count; i++) cells[i] = cells[i + 1];
      count--;
      return w;
    endfunction

    function void apply_request(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                                input logic [WORD_W-1:0] word);
      list_reply_t r;
      int          hit;
      r.word   = '0;
      r.status = ST_OK;
      hit      = -1;
      case (kind)
        KIND_PUSH: begin
          if (count >= CAP) begin
            r.status = ST_FULL;
          end else begin
            cells[count] = word;
            count++;
          end
        end
        KIND_POP: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            count--;
            r.word = cells[count];
          end
        end
        KIND_INSERT: begin
          if (int'(pos) > count) begin
            r.status = ST_RANGE;
          end else if (count >= CAP) begin
            r.status = ST_FULL;
          end else begin
            for (int i = count; i > int'(pos); i--) cells[i] = cells[i - 1];
            cells[int'(pos)] = word;
            count++;
          end
        end
        KIND_REMAT: begin
          if (int'(pos) >= count) r.status = ST_RANGE;
          else r.word = take_at(int'(pos));
        end
        KIND_REMVAL: begin
          for (int i = 0; i < count; i++) begin
            if (hit < 0 && cells[i] === word) hit = i;
          end
          if (hit < 0) r.status = ST_NOTFOUND;
          else r.word = take_at(hit);
        end
        KIND_READ: begin
          if (int'(pos) >= count) r.status = ST_RANGE;
          else r.word = cells[int'(pos)];
        end
        default: begin
        end
      endcase
      r.len = LEN_W'(count);
      replies.push_back(r);
    endfunction

    function void check_reply(input logic [WORD_W-1:0] word, input logic [STAT_W-1:0] status,
                              input logic [LEN_W-1:0] len);
      list_reply_t want;
      if (replies.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected reply beat: word %h status %0d length %0d", word, status, len);
        return;
      end
      want = replies.pop_front();
      if (word !== want.word || status !== want.status || len !== want.len) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("reply mismatch: word %h/%h status %0d/%0d length %0d/%0d (expected/actual)",
                   want.word, word, want.status, status, want.len, len);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ile_req_if in_if ();
  ile_rsp_if out_if ();

  indexed_list_engine_top #(.CAPACITY(CAP)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  list_scoreboard sb = new;

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int lull_pct     = 0;
  int issued       = 0;
  int episodes     = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1)
      sb.check_reply(out_if.word_out, out_if.status, out_if.length_now);
  end

  // A beat on either channel counts as progress.
  always @(posedge clk) begin
    if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[indexed_list_engine_top] ERROR");
      $finish;
    end
  end

  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                              input logic [WORD_W-1:0] word);
    int idle;
    idle = ($urandom_range(99) < lull_pct) ? 97 : snd_idle_pct;
    while ($urandom_range(99) < idle) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
    end
    @(negedge clk);
    in_if.valid    <= 1'b1;
    in_if.kind     <= kind;
    in_if.position <= pos;
    in_if.word_in  <= word;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    sb.apply_request(kind, pos, word);
  endtask

  task automatic drain_replies();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.replies.size() != 0) @(posedge clk);
  endtask

  // The list is steered towards a target length, so that both the empty and the full list
  // are reached often and the shifts work on long lists.
  task automatic random_request(input int target);
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] word;
    int                n;
    int                roll;
    n    = sb.count;
    roll = $urandom_range(99);
    if (roll < 8) kind = KIND_W'($urandom_range(7));
    else if (n < target && roll < 85) kind = $urandom_range(1) ? KIND_PUSH : KIND_INSERT;
    else if (n > target && roll < 85)
      kind = (roll < 35) ? KIND_POP : (roll < 60) ? KIND_REMAT : KIND_REMVAL;
    else kind = KIND_W'($urandom_range(5));

    roll = $urandom_range(99);
    if (roll < 15) pos = POS_W'($urandom_range(127));
    else if (roll < 25) pos = POS_W'(n);
    else if (kind == KIND_INSERT) pos = POS_W'($urandom_range(n));
    else pos = (n > 0) ? POS_W'($urandom_range(n - 1)) : '0;

    roll = $urandom_range(99);
    if (n > 0 && kind == KIND_REMVAL && roll < 65) word = sb.cells[$urandom_range(n - 1)];
    else if (n > 0 && kind == KIND_REMVAL && roll < 80)
      word = sb.cells[$urandom_range(n - 1)] ^ (64'd1 << $urandom_range(63));
    else if (n > 0 && roll < 15) word = sb.cells[$urandom_range(n - 1)];
    else if (roll > 90) word = $urandom_range(1) ? '1 : '0;
    else word = {$urandom, $urandom};

    send_request(kind, pos, word);
    if (kind <= KIND_READ) issued++;
  endtask

  task automatic run_phase(input int snd, input int rcv, input int items);
    int goal;
    int target;
    int span;
    snd_idle_pct = snd;
    rcv_idle_pct = rcv;
    lull_pct     = (snd > 0) ? 8 : 0;
    goal         = issued + items;
    while (issued < goal) begin
      span = $urandom_range(40, 150);
      if (episodes == 0 || $urandom_range(99) < 25) target = CAP;
      else if ($urandom_range(99) < 20) target = 0;
      else target = $urandom_range(CAP);
      episodes++;
      for (int k = 0; k < span && issued < goal; k++) random_request(target);
      if ($urandom_range(99) < 20) drain_replies();
    end
  endtask

  initial begin
    in_if.valid    = 1'b0;
    in_if.kind     = KIND_PUSH;
    in_if.position = '0;
    in_if.word_in  = '0;
    out_if.ready   = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_request(KIND_POP, 7'd0, '0);
    send_request(KIND_REMAT, 7'd0, '0);
    send_request(KIND_READ, 7'd0, '0);
    send_request(KIND_REMVAL, 7'd0, '0);
    send_request(KIND_INSERT, 7'd1, 64'h5555_5555_5555_5555);
    send_request(KIND_INSERT, 7'd0, '1);
    send_request(KIND_PUSH, 7'd0, '0);
    send_request(KIND_PUSH, 7'd127, '1);
    send_request(KIND_INSERT, 7'd3, 64'h8000_0000_0000_0001);
    send_request(KIND_INSERT, 7'd0, 64'h0123_4567_89ab_cdef);
    send_request(KIND_READ, 7'd127, '0);
    send_request(KIND_READ, 7'd5, '0);
    send_request(KIND_READ, 7'd4, '0);
    send_request(KIND_REMVAL, 7'd0, 64'h8000_0000_0000_0000);
    send_request(KIND_REMVAL, 7'd0, '1);
    send_request(KIND_SPARE6, 7'd0, '0);
    send_request(KIND_SPARE7, 7'd127, '1);
    send_request(KIND_REMAT, 7'd4, '0);
    send_request(KIND_REMAT, 7'd1, '0);
    send_request(KIND_INSERT, 7'd64, '1);
    send_request(KIND_POP, 7'd0, '0);
    send_request(KIND_POP, 7'd0, '0);
    send_request(KIND_POP, 7'd0, '0);
    send_request(KIND_POP, 7'd0, '0);
    drain_replies();

    run_phase(23, 74, 433);
    drain_replies();
    run_phase(74, 23, 433);
    drain_replies();
    run_phase(0, 0, 434);

    drain_replies();
    repeat (CAP + 8) @(posedge clk);
    if (sb.mismatches == 0 && sb.replies.size() == 0) begin
      $display("[indexed_list_engine_top] OK");
    end else begin
      $display("[indexed_list_engine_top] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/ile_pkg.sv
hw/rtl/ile_if.sv
hw/rtl/ile_cell.sv
hw/rtl/ile_chain.sv
hw/rtl/ile_ctrl.sv
hw/rtl/indexed_list_engine_top.sv
dv/tb.sv
